FILE: hdl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// types and constants shared by the triangle plane clipper
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int NATTR = 13;
  localparam int NCFG  = 6;

  localparam logic [2:0] CFG_NX = 3'd0;
  localparam logic [2:0] CFG_NY = 3'd1;
  localparam logic [2:0] CFG_NZ = 3'd2;
  localparam logic [2:0] CFG_PX = 3'd3;
  localparam logic [2:0] CFG_PY = 3'd4;
  localparam logic [2:0] CFG_PZ = 3'd5;

  typedef logic signed [31:0] word_t;
  typedef word_t [NATTR-1:0] vtx_t;

  typedef struct packed {
    vtx_t       a;
    vtx_t       b;
    vtx_t       c;
    logic [2:0] code;
    logic [7:0] shader;
    logic [15:0] tex;
    word_t      weight;
  } tri_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIST,
    BK_EDGE,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [3:0] {
    EG_IDLE,
    EG_DIV,
    EG_LERP,
    EG_SQ,
    EG_SQRT,
    EG_NDIV,
    EG_DONE
  } eg_state_t;

endpackage

FILE: hdl/triangle_plane_clipper.sv
// ----------------------------------------------------------------------------
// triangle_plane_clipper
// clips triangles against one configured plane
//
// channel  dir  handshake        word
// in_      in   push / full      one vertex
// out_     out  empty / pop      one emitted vertex, last_vertex ends a run
// cfg_     in   valid / ready    register index and data
//
// a triangle's third vertex queues it for the back end; the back end works out
// distances, then each crossing (divide, lerp, isqrt, three 32-step normal
// divides) in one shared edge unit, then emits one vertex per pop
// reset is synchronous; the front takes two more triangles while the back works
// ----------------------------------------------------------------------------
module triangle_plane_clipper import tpc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [63:0] in_pos_xy,
  input  logic [63:0] in_pos_zw,
  input  logic [63:0] in_normal_xy,
  input  logic signed [31:0] in_normal_z,
  input  logic [63:0] in_color_rg,
  input  logic signed [31:0] in_color_b,
  input  logic [63:0] in_tex_uv,
  input  logic signed [31:0] in_light_level,
  input  logic [7:0]  in_shader_id,
  input  logic [15:0] in_texture_id,
  input  logic signed [31:0] in_tri_weight,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_pos_xy,
  output logic [63:0] out_pos_zw,
  output logic [63:0] out_normal_xy,
  output logic signed [31:0] out_normal_z,
  output logic [63:0] out_color_rg,
  output logic signed [31:0] out_color_b,
  output logic [63:0] out_tex_uv,
  output logic signed [31:0] out_light,
  output logic [7:0]  out_shader_id,
  output logic [15:0] out_texture_id,
  output logic signed [31:0] out_weight,
  output logic        out_last_vertex,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  word_t cfg_r [NCFG];
  vtx_t vin, ov;
  logic jv, jt;
  tri_job_t job;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCFG; i++) begin
        cfg_r[i] <= (i == int'(CFG_NZ)) ? word_t'(32'sd1 <<< FRAC_BITS) : '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NX: cfg_r[0] <= cfg_data;
        CFG_NY: cfg_r[1] <= cfg_data;
        CFG_NZ: cfg_r[2] <= cfg_data;
        CFG_PX: cfg_r[3] <= cfg_data;
        CFG_PY: cfg_r[4] <= cfg_data;
        CFG_PZ: cfg_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign vin = {in_light_level, in_tex_uv[63:32], in_tex_uv[31:0], in_color_b,
                in_color_rg[63:32], in_color_rg[31:0], in_normal_z,
                in_normal_xy[63:32], in_normal_xy[31:0], in_pos_zw[63:32],
                in_pos_zw[31:0], in_pos_xy[63:32], in_pos_xy[31:0]};

  tpc_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .vin(vin),
    .shader(in_shader_id), .tex(in_texture_id), .weight(in_tri_weight),
    .job_valid(jv), .job_take(jt), .job(job)
  );

  tpc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .job_valid(jv), .job_take(jt),
    .job(job), .empty(empty), .pop(pop), .ov(ov), .osh(out_shader_id),
    .otex(out_texture_id), .owt(out_weight), .olast(out_last_vertex)
  );

  assign out_pos_xy    = {ov[1], ov[0]};
  assign out_pos_zw    = {ov[3], ov[2]};
  assign out_normal_xy = {ov[5], ov[4]};
  assign out_normal_z  = ov[6];
  assign out_color_rg  = {ov[8], ov[7]};
  assign out_color_b   = ov[9];
  assign out_tex_uv    = {ov[11], ov[10]};
  assign out_light     = ov[12];

endmodule

FILE: hdl/tpc_front.sv
// ----------------------------------------------------------------------------
// tpc_front
// collects three vertices of a triangle and queues the finished triangle
// ----------------------------------------------------------------------------
module tpc_front import tpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  vtx_t     vin,
  input  logic [7:0] shader,
  input  logic [15:0] tex,
  input  word_t    weight,
  output logic     job_valid,
  input  logic     job_take,
  output tri_job_t job
);

  logic [1:0] slot_r, slot_nxt;
  vtx_t       hold_a_r, hold_b_r;
  tri_job_t   q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  logic acc, enq;

  assign full      = (cnt_r == 2'd2);
  assign acc       = push && !full;
  assign enq       = acc && (slot_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];

  always_comb begin
    slot_nxt = slot_r;
    if (acc) slot_nxt = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 2'd0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      slot_r <= slot_nxt;
      if (enq) wp_r <= !wp_r;
      if (job_take && job_valid) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, enq} - {1'b0, job_take && job_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (acc && slot_r == 2'd0) hold_a_r <= vin;
    if (acc && slot_r == 2'd1) hold_b_r <= vin;
    if (enq) begin
      q_r[wp_r].a      <= hold_a_r;
      q_r[wp_r].b      <= hold_b_r;
      q_r[wp_r].c      <= vin;
      q_r[wp_r].code   <= 3'd0;
      q_r[wp_r].shader <= shader;
      q_r[wp_r].tex    <= tex;
      q_r[wp_r].weight <= weight;
    end
  end

endmodule

FILE: hdl/tpc_edge.sv
// ----------------------------------------------------------------------------
// tpc_edge
// one edge crossing: iterative divide, lerp, isqrt and normal renormalize
// ----------------------------------------------------------------------------
module tpc_edge import tpc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  vtx_t  va,
  input  vtx_t  vb,
  input  logic signed [63:0] da,
  input  logic signed [63:0] db,
  output logic  done,
  output vtx_t  vr
);

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  eg_state_t st_r, st_nxt;
  logic [63:0] rem_r, den_r;
  logic [FRAC_BITS:0] t_r;
  logic [5:0] it_r;
  logic [3:0] ai_r;
  vtx_t va_r, vb_r, r_r;
  logic [63:0] s_r, sx_r, sr_r, sbit_r;
  logic [63:0] len_r;
  logic [95:0] nrem_r;
  logic        nld_r;
  logic [1:0]  ni_r;

  logic signed [63:0] dden;
  logic [63:0] rem_sh;
  logic signed [32:0] diff;
  logic signed [33+FRAC_BITS:0] prod;
  logic signed [31:0] cc;
  logic [31:0] cmag;
  logic [63:0] sq;
  logic [64:0] nrs;
  logic        nq_bit;
  logic [63:0] nrs_sub;

  assign dden = da - db;
  assign rem_sh = {rem_r[62:0], 1'b0};
  assign diff = 33'(vb_r[ai_r]) - 33'(va_r[ai_r]);
  assign prod = (34+FRAC_BITS)'(diff) * $signed({1'b0, t_r});
  assign cc = r_r[4 + ni_r];
  assign cmag = cc[31] ? 32'(-cc) : 32'(cc);
  assign sq = 64'(cc) * 64'(cc);
  assign nrs = {nrem_r[95:32], 1'b0} | 65'(nrem_r[31]);
  assign nq_bit = (nrs >= {1'b0, len_r});
  assign nrs_sub = nq_bit ? 64'(nrs - {1'b0, len_r}) : 64'(nrs);
  assign done = (st_r == EG_DONE);
  assign vr = r_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      EG_IDLE: if (start) begin
        if (da <= 0 || da >= dden) st_nxt = EG_LERP;
        else st_nxt = EG_DIV;
      end
      EG_DIV:  if (it_r == 6'(FRAC_BITS - 1)) st_nxt = EG_LERP;
      EG_LERP: if (ai_r == 4'(NATTR - 1)) st_nxt = EG_SQ;
      EG_SQ:   if (ni_r == 2'd2) st_nxt = EG_SQRT;
      EG_SQRT: if (sbit_r == 64'd0) st_nxt = EG_NDIV;
      EG_NDIV: if (ni_r == 2'd2 && nld_r && (len_r == 64'd0 || it_r == 6'd31)) begin
        st_nxt = EG_DONE;
      end
      EG_DONE: st_nxt = EG_IDLE;
      default: st_nxt = EG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= EG_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      EG_IDLE: if (start) begin
        va_r <= va; vb_r <= vb; ai_r <= 4'd0; it_r <= 6'd0;
        rem_r <= 64'(da); den_r <= 64'(dden);
        if (da <= 0) t_r <= '0;
        else if (da >= dden) t_r <= (FRAC_BITS+1)'(ONE);
        else t_r <= '0;
      end
      EG_DIV: begin
        it_r <= it_r + 6'd1;
        if (rem_sh >= den_r) begin
          rem_r <= rem_sh - den_r;
          t_r <= {t_r[FRAC_BITS-1:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          t_r <= {t_r[FRAC_BITS-1:0], 1'b0};
        end
      end
      EG_LERP: begin
        r_r[ai_r] <= 32'(64'(va_r[ai_r]) + 64'(prod >>> FRAC_BITS));
        ai_r <= ai_r + 4'd1;
        ni_r <= 2'd0; s_r <= 64'd0;
      end
      EG_SQ: begin
        s_r <= s_r + sq;
        ni_r <= ni_r + 2'd1;
        sx_r <= s_r + sq; sr_r <= 64'd0; sbit_r <= 64'd1 << 62;
        if (r_r[12] > $signed(ONE)) r_r[12] <= $signed(ONE);
      end
      EG_SQRT: begin
        if (sbit_r != 64'd0) begin
          if (sx_r >= sr_r + sbit_r) begin
            sx_r <= sx_r - (sr_r + sbit_r);
            sr_r <= (sr_r >> 1) + sbit_r;
          end else sr_r <= sr_r >> 1;
          sbit_r <= sbit_r >> 2;
        end
        len_r <= sr_r;
        ni_r <= 2'd0; it_r <= 6'd0;
        nrem_r <= '0; nld_r <= 1'b0;
      end
      EG_NDIV: begin
        if (!nld_r) begin
          nrem_r <= {64'd0, cmag} << FRAC_BITS;
          nld_r <= 1'b1;
          it_r <= 6'd0;
        end else if (len_r == 64'd0) begin
          r_r[4 + ni_r] <= '0;
          ni_r <= ni_r + 2'd1; nld_r <= 1'b0;
        end else if (it_r == 6'd31) begin
          r_r[4 + ni_r] <= cc[31] ? -$signed({nrem_r[30:0], nq_bit}) :
                                    $signed({nrem_r[30:0], nq_bit});
          ni_r <= ni_r + 2'd1; nld_r <= 1'b0; it_r <= 6'd0;
        end else begin
          // 32-step shift-subtract, quotient collects in the low word
          nrem_r <= {nrs_sub, nrem_r[30:0], nq_bit};
          it_r <= it_r + 6'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/tpc_back.sv
// ----------------------------------------------------------------------------
// tpc_back
// classifies a queued triangle, builds crossings and emits vertex words
// ----------------------------------------------------------------------------
module tpc_back import tpc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  word_t    cfg [NCFG],
  input  logic     job_valid,
  output logic     job_take,
  input  tri_job_t job,
  output logic     empty,
  input  logic     pop,
  output vtx_t     ov,
  output logic [7:0] osh,
  output logic [15:0] otex,
  output word_t    owt,
  output logic     olast
);

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  bk_state_t st_r, st_nxt;
  tri_job_t j_r;
  logic signed [63:0] d_r [3];
  logic [1:0] di_r, ci_r;
  logic [1:0] ei_r;
  vtx_t x_r, y_r;
  logic [2:0] code;
  logic [2:0] oi_r;
  logic [2:0] nout;
  logic eg_start, eg_done;
  vtx_t ea, eb, er;
  logic signed [63:0] eda, edb;
  vtx_t vsel [3];
  logic signed [32:0] pd;
  word_t pds;
  logic signed [63:0] pm;
  vtx_t cur;
  logic busy_r;

  assign vsel[0] = j_r.a;
  assign vsel[1] = j_r.b;
  assign vsel[2] = j_r.c;
  assign code = {d_r[2] > 0, d_r[1] > 0, d_r[0] > 0};
  assign nout = (code == 3'd3 || code == 3'd5 || code == 3'd6) ? 3'd6 : 3'd3;

  assign pd  = 33'(vsel[di_r][ci_r]) - 33'(cfg[3 + ci_r]);
  assign pds = (pd > 33'sd2147483647) ? 32'sh7fffffff :
               (pd < -33'sd2147483648) ? 32'sh80000000 : 32'(pd);
  assign pm  = 64'(pds) * 64'(cfg[ci_r]);

  // edge endpoints per code and crossing index
  always_comb begin
    logic [1:0] ia, ib;
    ia = 2'd0; ib = 2'd1;
    case (code)
      3'd1: begin ia = 2'd0; ib = ei_r == 2'd0 ? 2'd1 : 2'd2; end
      3'd2: begin ia = 2'd1; ib = ei_r == 2'd0 ? 2'd0 : 2'd2; end
      3'd4: begin ia = 2'd2; ib = ei_r == 2'd0 ? 2'd0 : 2'd1; end
      3'd3: begin ia = ei_r == 2'd0 ? 2'd0 : 2'd1; ib = 2'd2; end
      3'd5: begin ia = ei_r == 2'd0 ? 2'd0 : 2'd2; ib = 2'd1; end
      3'd6: begin ia = ei_r == 2'd0 ? 2'd1 : 2'd2; ib = 2'd0; end
      default: ;
    endcase
    ea = vsel[ia]; eb = vsel[ib]; eda = d_r[ia]; edb = d_r[ib];
  end

  tpc_edge #(.FRAC_BITS(FRAC_BITS)) u_edge (
    .clk(clk), .rst_n(rst_n), .start(eg_start), .va(ea), .vb(eb),
    .da(eda), .db(edb), .done(eg_done), .vr(er)
  );

  // output vertex selection
  always_comb begin
    cur = j_r.a;
    case (code)
      3'd7: cur = vsel[oi_r[1:0]];
      3'd1: cur = oi_r == 3'd0 ? j_r.a : oi_r == 3'd1 ? x_r : y_r;
      3'd2: cur = oi_r == 3'd0 ? x_r : oi_r == 3'd1 ? j_r.b : y_r;
      3'd4: cur = oi_r == 3'd0 ? x_r : oi_r == 3'd1 ? y_r : j_r.c;
      3'd3: case (oi_r)
        3'd0: cur = j_r.a; 3'd1: cur = j_r.b; 3'd2: cur = x_r;
        3'd3: cur = x_r; 3'd4: cur = j_r.b; default: cur = y_r;
      endcase
      3'd5: case (oi_r)
        3'd0: cur = j_r.a; 3'd1: cur = x_r; 3'd2: cur = j_r.c;
        3'd3: cur = x_r; 3'd4: cur = y_r; default: cur = j_r.c;
      endcase
      3'd6: case (oi_r)
        3'd0: cur = x_r; 3'd1: cur = j_r.b; 3'd2: cur = j_r.c;
        3'd3: cur = y_r; 3'd4: cur = x_r; default: cur = j_r.c;
      endcase
      default: ;
    endcase
  end

  always_comb begin
    ov = cur;
    if (cur[12] > $signed(ONE)) ov[12] = $signed(ONE);
  end
  assign osh   = j_r.shader;
  assign otex  = j_r.tex;
  assign owt   = (nout == 3'd6) ? $signed(ONE) : j_r.weight;
  assign olast = (oi_r == nout - 3'd1);
  assign empty = (st_r != BK_EMIT);
  assign job_take = (st_r == BK_IDLE) && job_valid;
  assign eg_start = (st_r == BK_EDGE) && (code != 3'd0) && (code != 3'd7) &&
                    !busy_r && !eg_done && !(ei_r[1]);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (job_valid) st_nxt = BK_DIST;
      BK_DIST: if (di_r == 2'd2 && ci_r == 2'd2) st_nxt = BK_EDGE;
      BK_EDGE: begin
        if (code == 3'd0) st_nxt = BK_IDLE;
        else if (code == 3'd7 || ei_r == 2'd2) st_nxt = BK_EMIT;
      end
      BK_EMIT: if (pop && olast) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= BK_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else if (eg_start) busy_r <= 1'b1;
    else if (eg_done) busy_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      BK_IDLE: if (job_valid) begin
        j_r <= job; di_r <= 2'd0; ci_r <= 2'd0;
        d_r[0] <= '0; d_r[1] <= '0; d_r[2] <= '0;
      end
      BK_DIST: begin
        d_r[di_r] <= d_r[di_r] + (pm >>> 2);
        if (ci_r == 2'd2) begin ci_r <= 2'd0; di_r <= di_r + 2'd1; end
        else ci_r <= ci_r + 2'd1;
        ei_r <= 2'd0; oi_r <= 3'd0;
      end
      BK_EDGE: if (eg_done) begin
        if (ei_r == 2'd0) x_r <= er; else y_r <= er;
        ei_r <= ei_r + 2'd1;
      end
      BK_EMIT: if (pop) oi_r <= oi_r + 3'd1;
      default: ;
    endcase
  end

endmodule
